// ===== rtl/dual_wheel_incremental_pid_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the dual wheel incremental PID controller
// Both macros sample on the rising edge of clk_i and are off during reset.
// ----------------------------------------------------------------------------
`ifndef DUAL_WHEEL_INCREMENTAL_PID_MACROS_SVH
`define DUAL_WHEEL_INCREMENTAL_PID_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DWIP_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DWIP_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/dwip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwip_pkg
// Widths, register codes, shared types and saturating helpers of the
// dual wheel PID controller. All values are Q16.16, signed but for radius and limit.
// ----------------------------------------------------------------------------
package dwip_pkg;

  localparam int unsigned VAL_W  = 32;
  localparam int unsigned FRAC_W = 16;
  localparam int unsigned DT_W   = VAL_W - 1;
  localparam int unsigned PROD_W = 2 * VAL_W;
  localparam int unsigned RND_W  = PROD_W - FRAC_W;
  localparam int unsigned ACC_W  = RND_W + 2;
  localparam int unsigned DIVQ_W = VAL_W + FRAC_W;
  localparam int unsigned CFG_AW = 3;

  localparam logic [CFG_AW-1:0] CFG_GAIN_P_LEFT  = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_GAIN_P_RIGHT = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_GAIN_D_LEFT  = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_GAIN_D_RIGHT = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_GAIN_I_LEFT  = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_GAIN_I_RIGHT = 3'd5;
  localparam logic [CFG_AW-1:0] CFG_RADIUS       = 3'd6;
  localparam logic [CFG_AW-1:0] CFG_EFFORT_LIMIT = 3'd7;

  typedef logic signed [VAL_W-1:0] val_t;

  localparam val_t            RST_GAIN_P = 32'sd327680;
  localparam val_t            RST_GAIN_D = 32'sd65536;
  localparam val_t            RST_GAIN_I = 32'sd0;
  localparam logic [DT_W-1:0] RST_RADIUS = 31'd19661;
  localparam logic [DT_W-1:0] RST_LIMIT  = 31'd262144;

  typedef enum logic [3:0] {
    L_IDLE,
    L_MUL_SPEED,
    L_SPEED,
    L_ERROR,
    L_DIVIDE,
    L_MUL_P,
    L_MUL_D,
    L_MUL_I,
    L_ADD_I,
    L_CLAMP
  } lane_state_e;

  typedef struct packed {
    val_t            kp;
    val_t            kd;
    val_t            ki;
    logic [DT_W-1:0] radius;
    logic [DT_W-1:0] limit;
  } lane_cfg_t;

  typedef struct packed {
    val_t target;
    logic target_valid;
    val_t rate;
    logic rate_valid;
  } lane_in_t;

  function automatic val_t sat_wide(input logic signed [PROD_W-1:0] v);
    logic signed [PROD_W-1:0] vmax;
    logic signed [PROD_W-1:0] vmin;
    vmax = $signed({{(PROD_W-VAL_W+1){1'b0}}, {(VAL_W-1){1'b1}}});
    vmin = $signed({{(PROD_W-VAL_W+1){1'b1}}, {(VAL_W-1){1'b0}}});
    if (v > vmax) return vmax[VAL_W-1:0];
    if (v < vmin) return vmin[VAL_W-1:0];
    return v[VAL_W-1:0];
  endfunction

  function automatic val_t add_sat(input val_t a, input val_t b);
    logic [VAL_W:0] s;
    s = {a[VAL_W-1], a} + {b[VAL_W-1], b};
    return sat_wide({{(PROD_W-VAL_W-1){s[VAL_W]}}, s});
  endfunction

  function automatic val_t sub_sat(input val_t a, input val_t b);
    logic [VAL_W:0] s;
    s = {a[VAL_W-1], a} - {b[VAL_W-1], b};
    return sat_wide({{(PROD_W-VAL_W-1){s[VAL_W]}}, s});
  endfunction

  // Drop the fraction bits of a product, rounding half toward plus infinity.
  function automatic logic signed [RND_W-1:0] q_round(input logic signed [PROD_W-1:0] p);
    logic [PROD_W-1:0] s;
    s = p + {{(PROD_W-FRAC_W){1'b0}}, 1'b1, {(FRAC_W-1){1'b0}}};
    return s[PROD_W-1:FRAC_W];
  endfunction

endpackage

// ===== rtl/dwip_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwip_div
// Iterative signed divider for the derivative term: (de << FRAC_W) / dt,
// truncated toward zero and saturated. Two quotient bits per cycle.
// ----------------------------------------------------------------------------
module dwip_div (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  dwip_pkg::val_t        dividend_i,
  input  logic [dwip_pkg::DT_W-1:0] divisor_i,
  output logic                  done_o,
  output dwip_pkg::val_t        quot_o
);
  import dwip_pkg::*;

  localparam int unsigned STEPS    = 2;
  localparam int unsigned DIV_ITER = DIVQ_W / STEPS;
  localparam int unsigned CNT_W    = $clog2(DIV_ITER + 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              neg_q;
  logic [VAL_W-1:0]  rem_q, rem_d;
  logic [DIVQ_W-1:0] quo_q, quo_d;
  logic [VAL_W-1:0]  den_q;
  logic [VAL_W-1:0]  mag;
  logic [DIVQ_W:0]   qs;

  assign mag = dividend_i[VAL_W-1] ? (~dividend_i + 1'b1) : dividend_i;

  always_comb begin
    logic [VAL_W-1:0] r;
    logic [VAL_W-1:0] sh;
    logic [DIVQ_W-1:0] q;
    r = rem_q;
    q = quo_q;
    // Restoring steps: the remainder stays below the divisor, so one bit of
    // headroom is enough for the shifted value.
    for (int i = 0; i < STEPS; i++) begin
      sh = {r[VAL_W-2:0], q[DIVQ_W-1]};
      q  = {q[DIVQ_W-2:0], 1'b0};
      if (sh >= den_q) begin
        r    = sh - den_q;
        q[0] = 1'b1;
      end else begin
        r = sh;
      end
    end
    rem_d  = r;
    quo_d  = q;
    busy_d = busy_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CNT_W'(DIV_ITER);
    end else if (busy_q) begin
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[VAL_W-1];
      rem_q <= '0;
      quo_q <= {mag, {FRAC_W{1'b0}}};
      den_q <= {1'b0, divisor_i};
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign qs     = neg_q ? (~{1'b0, quo_q} + 1'b1) : {1'b0, quo_q};
  assign quot_o = sat_wide({{(PROD_W-DIVQ_W-1){qs[DIVQ_W]}}, qs});
  assign done_o = done_q;

endmodule

// ===== rtl/dwip_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwip_lane
// One wheel of the controller: speed conversion, error, derivative and
// error sum, then the three gain terms through one shared multiplier.
// ----------------------------------------------------------------------------
module dwip_lane (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  dwip_pkg::lane_in_t        in_i,
  input  logic [dwip_pkg::DT_W-1:0] dt_i,
  input  dwip_pkg::lane_cfg_t       cfg_i,
  output logic                      done_o,
  output dwip_pkg::val_t            effort_o,
  output dwip_pkg::val_t            speed_o
);
  import dwip_pkg::*;

  lane_state_e state_q, state_d;

  val_t              target_q, speed_q, prev_q, sum_q, effort_q;
  val_t              rate_q, e_q, d_q;
  logic              rate_valid_q;
  logic [DT_W-1:0]   dt_q;
  logic [PROD_W-1:0] prod_q;
  logic [ACC_W-1:0]  acc_q;

  logic signed [VAL_W:0]     mul_a, mul_b;
  logic signed [2*VAL_W+1:0] mul_full;
  logic signed [RND_W-1:0]   rnd;
  val_t                      speed_val, e_val, de_val, acc_sat, lim, effort_val;
  logic                      div_start, div_done;
  val_t                      div_quot;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      L_MUL_SPEED: begin
        mul_a = {rate_q[VAL_W-1], rate_q};
        mul_b = {2'b00, cfg_i.radius};
      end
      L_MUL_P: begin
        mul_a = {e_q[VAL_W-1], e_q};
        mul_b = {cfg_i.kp[VAL_W-1], cfg_i.kp};
      end
      L_MUL_D: begin
        mul_a = {d_q[VAL_W-1], d_q};
        mul_b = {cfg_i.kd[VAL_W-1], cfg_i.kd};
      end
      L_MUL_I: begin
        mul_a = {sum_q[VAL_W-1], sum_q};
        mul_b = {cfg_i.ki[VAL_W-1], cfg_i.ki};
      end
      default: ;
    endcase
  end

  assign mul_full  = mul_a * mul_b;
  assign rnd       = q_round(prod_q);
  assign speed_val = sat_wide({{(PROD_W-RND_W){rnd[RND_W-1]}}, rnd});
  assign e_val     = sub_sat(target_q, speed_q);
  assign de_val    = sub_sat(e_val, prev_q);
  assign acc_sat   = sat_wide({{(PROD_W-ACC_W){acc_q[ACC_W-1]}}, acc_q});
  assign lim       = {1'b0, cfg_i.limit};

  always_comb begin
    if (acc_sat > lim) begin
      effort_val = lim;
    end else if (acc_sat < -lim) begin
      effort_val = -lim;
    end else begin
      effort_val = acc_sat;
    end
  end

  assign div_start = (state_q == L_ERROR) && (dt_q != '0);

  dwip_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (de_val),
    .divisor_i  (dt_q),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      L_IDLE:      if (start_i) state_d = L_MUL_SPEED;
      L_MUL_SPEED: state_d = L_SPEED;
      L_SPEED:     state_d = L_ERROR;
      L_ERROR:     state_d = (dt_q != '0) ? L_DIVIDE : L_MUL_P;
      L_DIVIDE:    if (div_done) state_d = L_MUL_P;
      L_MUL_P:     state_d = L_MUL_D;
      L_MUL_D:     state_d = L_MUL_I;
      L_MUL_I:     state_d = L_ADD_I;
      L_ADD_I:     state_d = L_CLAMP;
      L_CLAMP:     state_d = L_IDLE;
      default:     state_d = L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= L_IDLE;
      target_q <= '0;
      speed_q  <= '0;
      prev_q   <= '0;
      sum_q    <= '0;
      effort_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == L_IDLE && start_i && in_i.target_valid) begin
        target_q <= in_i.target;
      end
      if (state_q == L_SPEED && rate_valid_q) begin
        speed_q <= speed_val;
      end
      if (state_q == L_ERROR) begin
        prev_q <= e_val;
        sum_q  <= add_sat(sum_q, e_val);
      end
      if (state_q == L_CLAMP) begin
        effort_q <= effort_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_full[PROD_W-1:0];
    if (state_q == L_IDLE && start_i) begin
      rate_q       <= in_i.rate;
      rate_valid_q <= in_i.rate_valid;
      dt_q         <= dt_i;
    end
    if (state_q == L_ERROR) begin
      e_q <= e_val;
      d_q <= '0;
    end
    if (state_q == L_DIVIDE && div_done) begin
      d_q <= div_quot;
    end
    // The product of one gain term is added in the cycle after it is formed.
    if (state_q == L_MUL_P) begin
      acc_q <= {{(ACC_W-VAL_W){effort_q[VAL_W-1]}}, effort_q};
    end else if (state_q == L_MUL_D || state_q == L_MUL_I || state_q == L_ADD_I) begin
      acc_q <= acc_q + {{(ACC_W-RND_W){rnd[RND_W-1]}}, rnd};
    end
  end

  assign done_o   = (state_q == L_CLAMP);
  assign effort_o = effort_q;
  assign speed_o  = speed_q;

endmodule

// ===== rtl/dual_wheel_incremental_pid.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dual_wheel_incremental_pid
// Two-wheel incremental PID speed controller with one lane per wheel and an
// output register that merges both lanes into one result word.
// ----------------------------------------------------------------------------
//  Channel   Handshake                 Payload
//  input     in_valid_i / in_ready_o   setpoints, joint rates, flags, elapsed
//  output    out_valid_o / out_ready_i efforts and stored speeds
//  config    cfg_we_i                  cfg_addr_i, cfg_data_i
//
// When elapsed is zero the derivative divider is skipped; otherwise it
// runs at two quotient bits a cycle.
// in_ready_o is high whenever both lanes are free, so the next word may be
// accepted while a result still waits at the output.
// A finished word waits in its lane while the output register is stalled.
// Async reset clears control and lane history; no clearing pass is needed.
// ----------------------------------------------------------------------------
module dual_wheel_incremental_pid (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  dwip_pkg::val_t              left_target_i,
  input  logic                        left_target_valid_i,
  input  dwip_pkg::val_t              right_target_i,
  input  logic                        right_target_valid_i,
  input  dwip_pkg::val_t              left_joint_rate_i,
  input  logic                        left_joint_valid_i,
  input  dwip_pkg::val_t              right_joint_rate_i,
  input  logic                        right_joint_valid_i,
  input  logic [dwip_pkg::DT_W-1:0]   elapsed_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output dwip_pkg::val_t              left_effort_o,
  output dwip_pkg::val_t              right_effort_o,
  output dwip_pkg::val_t              left_speed_o,
  output dwip_pkg::val_t              right_speed_o,
  input  logic                        cfg_we_i,
  input  logic [dwip_pkg::CFG_AW-1:0] cfg_addr_i,
  input  dwip_pkg::val_t              cfg_data_i
);
  import dwip_pkg::*;

  val_t            kp_l_q, kp_r_q, kd_l_q, kd_r_q, ki_l_q, ki_r_q;
  logic [DT_W-1:0] radius_q, limit_q;

  logic      busy_q, busy_d;
  logic      done_l_q, done_l_d, done_r_q, done_r_d;
  logic      out_valid_q, out_valid_d;
  logic      start, load;
  val_t      eff_l_q, eff_r_q, spd_l_q, spd_r_q;
  lane_cfg_t cfg_l, cfg_r;
  lane_in_t  in_l, in_r;
  logic      lane_done_l, lane_done_r;
  val_t      lane_eff_l, lane_eff_r, lane_spd_l, lane_spd_r;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kp_l_q   <= RST_GAIN_P;
      kp_r_q   <= RST_GAIN_P;
      kd_l_q   <= RST_GAIN_D;
      kd_r_q   <= RST_GAIN_D;
      ki_l_q   <= RST_GAIN_I;
      ki_r_q   <= RST_GAIN_I;
      radius_q <= RST_RADIUS;
      limit_q  <= RST_LIMIT;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        CFG_GAIN_P_LEFT:  kp_l_q   <= cfg_data_i;
        CFG_GAIN_P_RIGHT: kp_r_q   <= cfg_data_i;
        CFG_GAIN_D_LEFT:  kd_l_q   <= cfg_data_i;
        CFG_GAIN_D_RIGHT: kd_r_q   <= cfg_data_i;
        CFG_GAIN_I_LEFT:  ki_l_q   <= cfg_data_i;
        CFG_GAIN_I_RIGHT: ki_r_q   <= cfg_data_i;
        CFG_RADIUS:       radius_q <= cfg_data_i[DT_W-1:0];
        CFG_EFFORT_LIMIT: limit_q  <= cfg_data_i[DT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_l = '{kp: kp_l_q, kd: kd_l_q, ki: ki_l_q, radius: radius_q, limit: limit_q};
  assign cfg_r = '{kp: kp_r_q, kd: kd_r_q, ki: ki_r_q, radius: radius_q, limit: limit_q};
  assign in_l  = '{target: left_target_i, target_valid: left_target_valid_i,
                   rate: left_joint_rate_i, rate_valid: left_joint_valid_i};
  assign in_r  = '{target: right_target_i, target_valid: right_target_valid_i,
                   rate: right_joint_rate_i, rate_valid: right_joint_valid_i};

  assign in_ready_o = !busy_q;
  assign start      = in_valid_i && in_ready_o;

  dwip_lane u_lane_left (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .in_i     (in_l),
    .dt_i     (elapsed_i),
    .cfg_i    (cfg_l),
    .done_o   (lane_done_l),
    .effort_o (lane_eff_l),
    .speed_o  (lane_spd_l)
  );

  dwip_lane u_lane_right (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .in_i     (in_r),
    .dt_i     (elapsed_i),
    .cfg_i    (cfg_r),
    .done_o   (lane_done_r),
    .effort_o (lane_eff_r),
    .speed_o  (lane_spd_r)
  );

  // Merge: the word moves to the output once both lanes are finished and
  // the output register is free or being emptied.
  always_comb begin
    load        = done_l_q && done_r_q && (!out_valid_q || out_ready_i);
    done_l_d    = done_l_q || lane_done_l;
    done_r_d    = done_r_q || lane_done_r;
    busy_d      = busy_q || start;
    out_valid_d = out_valid_q && !out_ready_i;
    if (load) begin
      done_l_d    = 1'b0;
      done_r_d    = 1'b0;
      busy_d      = 1'b0;
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      done_l_q    <= 1'b0;
      done_r_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q      <= busy_d;
      done_l_q    <= done_l_d;
      done_r_q    <= done_r_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      eff_l_q <= lane_eff_l;
      eff_r_q <= lane_eff_r;
      spd_l_q <= lane_spd_l;
      spd_r_q <= lane_spd_r;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign left_effort_o  = eff_l_q;
  assign right_effort_o = eff_r_q;
  assign left_speed_o   = spd_l_q;
  assign right_speed_o  = spd_r_q;

endmodule

// ===== rtl/dwip_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dwip_checker
// Port-level checks of the controller's handshakes and result timing,
// attached to the top level by a bind.
// ----------------------------------------------------------------------------
`include "dual_wheel_incremental_pid_macros.svh"

module dwip_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_ready_o,
  input logic           out_valid_o,
  input logic           out_ready_i,
  input dwip_pkg::val_t left_effort_o,
  input dwip_pkg::val_t right_effort_o,
  input dwip_pkg::val_t left_speed_o,
  input dwip_pkg::val_t right_speed_o
);

  // After a word is accepted, the input is not ready in the next cycle.
  `DWIP_ASSERT_NEXT(a_busy_after_accept, in_valid_i && in_ready_o, !in_ready_o)

  // A new result only appears when a word in flight completes and frees the input.
  `DWIP_ASSERT_NOW(a_result_frees_input, $rose(out_valid_o), in_ready_o && !$past(in_ready_o))

  // A stalled result stays put.
  `DWIP_ASSERT_NEXT(a_result_held, out_valid_o && !out_ready_i,
                    out_valid_o && $stable(left_effort_o) && $stable(right_effort_o)
                    && $stable(left_speed_o) && $stable(right_speed_o))

endmodule

bind dual_wheel_incremental_pid dwip_checker u_dwip_checker (.*);

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the dual wheel incremental PID controller. A short
// table of directed ticks runs first, then eight randomized phases, each with
// its own gain, radius and limit setting and one of four patterns of input
// gaps and output stalls. Every accepted result word is checked against the
// table's expected values or an in-bench fixed point model of both wheels.
// ----------------------------------------------------------------------------
module tb;
  import dwip_pkg::*;

  localparam val_t TOP    = 32'sh7FFF_FFFF;
  localparam val_t BOTTOM = 32'sh8000_0000;
  localparam val_t LIMIT0 = val_t'({1'b0, RST_LIMIT});
  localparam int   DRAIN_CYCLES   = 60;
  localparam int   STALL_LIMIT    = 4000;
  localparam int   PHASES         = 8;
  localparam int   TICKS_PER_PHASE = 56;

  typedef struct packed {
    val_t            lt;
    logic            ltv;
    val_t            rt;
    logic            rtv;
    val_t            lj;
    logic            ljv;
    val_t            rj;
    logic            rjv;
    logic [DT_W-1:0] dt;
  } tick_t;

  typedef struct packed {
    val_t le;
    val_t re;
    val_t ls;
    val_t rs;
  } efforts_t;

  typedef struct {
    tick_t    t;
    bit       has_want;
    efforts_t want;
  } tick_row_t;

  logic            clk_i = 1'b0;
  logic            rst_n = 1'b0;
  logic            in_valid = 1'b0;
  logic            in_ready_o;
  val_t            left_target = '0;
  logic            left_target_valid = 1'b0;
  val_t            right_target = '0;
  logic            right_target_valid = 1'b0;
  val_t            left_joint_rate = '0;
  logic            left_joint_valid = 1'b0;
  val_t            right_joint_rate = '0;
  logic            right_joint_valid = 1'b0;
  logic [DT_W-1:0] elapsed = '0;
  logic            out_valid_o;
  logic            out_ready = 1'b0;
  val_t            left_effort_o, right_effort_o, left_speed_o, right_speed_o;
  logic            cfg_we = 1'b0;
  logic [CFG_AW-1:0] cfg_addr = '0;
  val_t            cfg_data = '0;

  dual_wheel_incremental_pid dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_n),
    .in_valid_i           (in_valid),
    .in_ready_o           (in_ready_o),
    .left_target_i        (left_target),
    .left_target_valid_i  (left_target_valid),
    .right_target_i       (right_target),
    .right_target_valid_i (right_target_valid),
    .left_joint_rate_i    (left_joint_rate),
    .left_joint_valid_i   (left_joint_valid),
    .right_joint_rate_i   (right_joint_rate),
    .right_joint_valid_i  (right_joint_valid),
    .elapsed_i            (elapsed),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready),
    .left_effort_o        (left_effort_o),
    .right_effort_o       (right_effort_o),
    .left_speed_o         (left_speed_o),
    .right_speed_o        (right_speed_o),
    .cfg_we_i             (cfg_we),
    .cfg_addr_i           (cfg_addr),
    .cfg_data_i           (cfg_data)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Model state, index 0 is the left wheel and 1 the right wheel.
  val_t            kp [2];
  val_t            kd [2];
  val_t            ki [2];
  logic [DT_W-1:0] axle_radius;
  logic [DT_W-1:0] effort_limit;
  val_t            setpoint [2];
  val_t            speed [2];
  val_t            prev_err [2];
  val_t            err_sum [2];
  val_t            effort [2];

  efforts_t pending_efforts[$];
  int       mismatch_count = 0;
  int       tx_idle_pct = 0;
  int       rx_stall_pct = 0;
  int       quiet_cycles = 0;

  function automatic longint clip(input longint v);
    if (v > longint'(TOP)) return longint'(TOP);
    if (v < longint'(BOTTOM)) return longint'(BOTTOM);
    return v;
  endfunction

  // Exact product, then drop the fraction rounding half toward plus infinity.
  function automatic longint fx_mul(input longint a, input longint b);
    longint p;
    p = a * b;
    return (p + (longint'(1) << (FRAC_W - 1))) >>> FRAC_W;
  endfunction

  function automatic efforts_t predict_tick(input tick_t t);
    efforts_t r;
    longint   dt, e, de, d, acc, lim;
    int       w;
    dt  = longint'(t.dt);
    lim = longint'(effort_limit);
    if (t.ltv) setpoint[0] = t.lt;
    if (t.rtv) setpoint[1] = t.rt;
    if (t.ljv) speed[0] = val_t'(clip(fx_mul(longint'(t.lj), longint'(axle_radius))));
    if (t.rjv) speed[1] = val_t'(clip(fx_mul(longint'(t.rj), longint'(axle_radius))));
    for (w = 0; w < 2; w++) begin
      e  = clip(longint'(setpoint[w]) - longint'(speed[w]));
      de = clip(e - longint'(prev_err[w]));
      d  = 0;
      if (dt != 0) d = clip((de * (longint'(1) << FRAC_W)) / dt);
      err_sum[w]  = val_t'(clip(longint'(err_sum[w]) + e));
      prev_err[w] = val_t'(e);
      acc = longint'(effort[w]) + fx_mul(longint'(kp[w]), e) + fx_mul(longint'(kd[w]), d)
            + fx_mul(longint'(ki[w]), longint'(err_sum[w]));
      acc = clip(acc);
      if (acc > lim) acc = lim;
      if (acc < -lim) acc = -lim;
      effort[w] = val_t'(acc);
    end
    r.le = effort[0];
    r.re = effort[1];
    r.ls = speed[0];
    r.rs = speed[1];
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_word();
    efforts_t want;
    if (pending_efforts.size() == 0) begin
      report_mismatch("result word with no tick pending");
    end else begin
      want = pending_efforts.pop_front();
      if (left_effort_o !== want.le)
        report_mismatch($sformatf("left_effort %0d, want %0d", left_effort_o, want.le));
      if (right_effort_o !== want.re)
        report_mismatch($sformatf("right_effort %0d, want %0d", right_effort_o, want.re));
      if (left_speed_o !== want.ls)
        report_mismatch($sformatf("left_speed %0d, want %0d", left_speed_o, want.ls));
      if (right_speed_o !== want.rs)
        report_mismatch($sformatf("right_speed %0d, want %0d", right_speed_o, want.rs));
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_n && out_valid_o && out_ready) check_word();
    out_ready <= ($urandom_range(99) >= rx_stall_pct);
  end

  // Watchdog: any run that stops moving words for too long is a failure.
  always @(posedge clk_i) begin
    if (rst_n) begin
      if ((in_valid && in_ready_o) || (out_valid_o && out_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no word moved for %0d cycles", $time, STALL_LIMIT);
        $display("TEST FAILED");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic write_reg(input logic [CFG_AW-1:0] idx, input val_t data);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= data;
    @(posedge clk_i);
    case (idx)
      CFG_GAIN_P_LEFT:  kp[0] = data;
      CFG_GAIN_P_RIGHT: kp[1] = data;
      CFG_GAIN_D_LEFT:  kd[0] = data;
      CFG_GAIN_D_RIGHT: kd[1] = data;
      CFG_GAIN_I_LEFT:  ki[0] = data;
      CFG_GAIN_I_RIGHT: ki[1] = data;
      CFG_RADIUS:       axle_radius = data[DT_W-1:0];
      CFG_EFFORT_LIMIT: effort_limit = data[DT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic write_all(input val_t kpl, input val_t kpr, input val_t kdl, input val_t kdr,
                           input val_t kil, input val_t kir, input val_t rad, input val_t lim);
    write_reg(CFG_GAIN_P_LEFT, kpl);
    write_reg(CFG_GAIN_P_RIGHT, kpr);
    write_reg(CFG_GAIN_D_LEFT, kdl);
    write_reg(CFG_GAIN_D_RIGHT, kdr);
    write_reg(CFG_GAIN_I_LEFT, kil);
    write_reg(CFG_GAIN_I_RIGHT, kir);
    write_reg(CFG_RADIUS, rad);
    write_reg(CFG_EFFORT_LIMIT, lim);
    cfg_we <= 1'b0;
  endtask

  task automatic send_tick(input tick_t t, input bit has_want, input efforts_t want);
    efforts_t model_out;
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid           <= 1'b1;
    left_target        <= t.lt;
    left_target_valid  <= t.ltv;
    right_target       <= t.rt;
    right_target_valid <= t.rtv;
    left_joint_rate    <= t.lj;
    left_joint_valid   <= t.ljv;
    right_joint_rate   <= t.rj;
    right_joint_valid  <= t.rjv;
    elapsed            <= t.dt;
    do @(posedge clk_i); while (!in_ready_o);
    model_out = predict_tick(t);
    pending_efforts.push_back(has_want ? want : model_out);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_efforts.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic tick_t mk_tick(input val_t lt, input logic ltv, input val_t rt,
                                    input logic rtv, input val_t lj, input logic ljv,
                                    input val_t rj, input logic rjv,
                                    input logic [DT_W-1:0] dt);
    tick_t t;
    t.lt = lt; t.ltv = ltv; t.rt = rt; t.rtv = rtv;
    t.lj = lj; t.ljv = ljv; t.rj = rj; t.rjv = rjv;
    t.dt = dt;
    return t;
  endfunction

  // Half modest speeds, with the rails and full-width noise mixed in.
  function automatic val_t gen_value();
    case ($urandom_range(7))
      0:       return TOP;
      1:       return BOTTOM;
      2, 3:    return val_t'($urandom);
      default: return val_t'($urandom_range(2097152)) - val_t'(1048576);
    endcase
  endfunction

  function automatic logic [DT_W-1:0] gen_elapsed();
    case ($urandom_range(15))
      0, 1:    return '0;
      2:       return DT_W'(1);
      3:       return '1;
      4, 5:    return DT_W'($urandom);
      default: return DT_W'($urandom_range(131072, 1));
    endcase
  endfunction

  function automatic tick_t gen_tick();
    return mk_tick(gen_value(), $urandom_range(3) != 0, gen_value(), $urandom_range(3) != 0,
                   gen_value(), $urandom_range(3) != 0, gen_value(), $urandom_range(3) != 0,
                   gen_elapsed());
  endfunction

  function automatic val_t gen_gain();
    if ($urandom_range(3) == 0) return val_t'($urandom);
    return val_t'($urandom_range(1048576)) - val_t'(524288);
  endfunction

  // Bit 31 of radius and limit writes is random; the block must ignore it.
  function automatic val_t gen_unsigned_reg(input int unsigned small_max);
    logic [DT_W-1:0] v;
    if ($urandom_range(3) == 0) v = DT_W'($urandom);
    else v = DT_W'($urandom_range(small_max));
    return val_t'({1'($urandom_range(1)), v});
  endfunction

  initial begin
    tick_row_t rows[$];
    efforts_t  none;
    int        phase, n;
    none = '0;

    kp[0] = RST_GAIN_P; kp[1] = RST_GAIN_P;
    kd[0] = RST_GAIN_D; kd[1] = RST_GAIN_D;
    ki[0] = RST_GAIN_I; ki[1] = RST_GAIN_I;
    axle_radius = RST_RADIUS;
    effort_limit = RST_LIMIT;
    for (n = 0; n < 2; n++) begin
      setpoint[n] = '0; speed[n] = '0; prev_err[n] = '0; err_sum[n] = '0; effort[n] = '0;
    end

    repeat (3) @(posedge clk_i);
    rst_n <= 1'b1;
    @(posedge clk_i);

    // Directed ticks under the reset gains. The first three have results that
    // follow directly: nothing set, then both setpoints at the rails with no
    // elapsed time so the effort hits the clamp, then every flag clear with
    // junk in the value fields so the stored values must be kept.
    rows.push_back('{mk_tick('0, 0, '0, 0, '0, 0, '0, 0, '0), 1, '{'0, '0, '0, '0}});
    rows.push_back('{mk_tick(TOP, 1, BOTTOM, 1, '0, 0, '0, 0, '0), 1,
                     '{LIMIT0, -LIMIT0, '0, '0}});
    rows.push_back('{mk_tick(32'sh5A5A_5A5A, 0, 32'shA5A5_A5A5, 0, 32'sh1234_5678, 0,
                             32'shEDCB_A987, 0, '0), 1, '{LIMIT0, -LIMIT0, '0, '0}});
    rows.push_back('{mk_tick('0, 0, '0, 0, TOP, 1, BOTTOM, 1, 31'd1), 0, none});
    rows.push_back('{mk_tick('0, 0, '0, 0, BOTTOM, 1, TOP, 1, '1), 0, none});
    rows.push_back('{mk_tick(BOTTOM, 1, TOP, 1, '0, 0, '0, 0, 31'd1), 0, none});
    rows.push_back('{mk_tick(32'sd65536, 1, 32'sd65536, 1, '0, 1, '0, 1, 31'd1311), 0, none});
    rows.push_back('{mk_tick('0, 0, '0, 0, 32'sd196608, 1, 32'sd196608, 1, 31'd1311),
                     0, none});
    rows.push_back('{mk_tick('1, 0, '1, 0, '1, 0, '1, 0, 31'd1311), 0, none});
    rows.push_back('{mk_tick('0, 0, '0, 0, 32'sh7777_7777, 0, 32'sh8888_8888, 0, '0),
                     0, none});
    rows.push_back('{mk_tick(-32'sd65536, 1, -32'sd65536, 1, '0, 0, '0, 0, 31'd65536),
                     0, none});
    rows.push_back('{mk_tick('0, 1, '0, 1, '0, 1, '0, 1, 31'd32768), 0, none});
    foreach (rows[i]) send_tick(rows[i].t, rows[i].has_want, rows[i].want);
    wait_drained();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: write_all(RST_GAIN_P, RST_GAIN_P, RST_GAIN_D, RST_GAIN_D, 32'sd16384,
                     -32'sd16384, val_t'({1'b1, RST_RADIUS}), val_t'({1'b1, RST_LIMIT}));
        1: write_all(TOP, TOP, TOP, TOP, TOP, TOP, 32'shFFFF_FFFF, 32'sh8000_0000);
        2: write_all(BOTTOM, BOTTOM, BOTTOM, BOTTOM, BOTTOM, BOTTOM, '0, TOP);
        default: write_all(gen_gain(), gen_gain(), gen_gain(), gen_gain(), gen_gain(),
                           gen_gain(), gen_unsigned_reg(131072), gen_unsigned_reg(1048576));
      endcase
      case (phase % 4)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 50; end
        default: begin tx_idle_pct = 35; rx_stall_pct = 35; end
      endcase
      for (n = 0; n < TICKS_PER_PHASE; n++) send_tick(gen_tick(), 0, none);
      wait_drained();
    end

    if (pending_efforts.size() != 0)
      report_mismatch($sformatf("%0d result words never arrived", pending_efforts.size()));
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
